// ===== hdl/ordered_array_list_unit_defines.svh =====
// Assertion macros for the ordered array list unit.
// Included by the module that carries concurrent checks; no other dependencies.
`ifndef ORDERED_ARRAY_LIST_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define OAL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("oal assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("oal assertion failed");
`else
`define OAL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/oal_pkg.sv =====
// Shared constants, command codes and result type for the ordered array list unit.
// No dependencies.
package oal_pkg;

    localparam int OAL_DEPTH   = 64;
    localparam int OAL_VALUE_W = 16;
    localparam int OAL_CMD_W   = 3;
    localparam int OAL_POS_W   = 7;
    localparam int OAL_FPOS_W  = 6;
    localparam int OAL_COUNT_W = 7;

    localparam logic [OAL_CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [OAL_CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [OAL_CMD_W-1:0] CMD_REMOVE  = 3'd2;
    localparam logic [OAL_CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [OAL_CMD_W-1:0] CMD_REPLACE = 3'd4;
    localparam logic [OAL_CMD_W-1:0] CMD_FIND    = 3'd5;

    typedef struct packed {
        logic                   ok;
        logic [OAL_VALUE_W-1:0] read_value;
        logic [OAL_FPOS_W-1:0]  found_position;
        logic                   found;
        logic [OAL_COUNT_W-1:0] entry_count;
        logic                   is_empty;
    } t_result;

endpackage

// ===== hdl/oal_store.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on oal_pkg for the value width.
module oal_store import oal_pkg::*; #(
    parameter int DEPTH = OAL_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [OAL_VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [OAL_VALUE_W-1:0] o_rdata
);

    logic [OAL_VALUE_W-1:0] r_mem [DEPTH];
    logic [OAL_VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/oal_seq.sv =====
// Command sequencer: decodes one command, walks the store through the shared
// address/compare unit, and keeps the entry count. Depends on oal_pkg and the defines header.
`include "ordered_array_list_unit_defines.svh"
module oal_seq import oal_pkg::*; #(
    parameter int DEPTH = OAL_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [OAL_CMD_W-1:0]   i_command,
    input  logic [OAL_POS_W-1:0]   i_position,
    input  logic [OAL_VALUE_W-1:0] i_item_value,
    output logic                   o_ready,
    output logic                   o_done,
    input  logic                   i_free,
    output t_result                o_result,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output logic [OAL_VALUE_W-1:0] o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  logic [OAL_VALUE_W-1:0] i_mem_rdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > OAL_POS_W) ? CW : OAL_POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PUTVAL = 3'd3;
    localparam logic [2:0] S_FIND   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [OAL_CMD_W-1:0]   r_cmd, n_cmd;
    logic [OAL_POS_W-1:0]   r_pos, n_pos;
    logic [OAL_VALUE_W-1:0] r_val, n_val;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_lim, n_lim;
    logic                   r_up, n_up;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_tgt, n_tgt;
    logic                   r_ok, n_ok;
    logic [OAL_VALUE_W-1:0] r_rd, n_rd;
    logic [AW-1:0]          r_fpos, n_fpos;
    logic                   r_fnd, n_fnd;

    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] count_w;
    logic [CMPW-1:0] fpos_w;
    logic [AW-1:0]   pos_a;
    logic            pos_le_cnt;
    logic            pos_lt_cnt;
    logic            not_full;
    logic            walk_on;
    logic [CW-1:0]   idx_step;

    assign pos_w      = CMPW'(r_pos);
    assign count_w    = CMPW'(r_count);
    assign fpos_w     = CMPW'(r_fpos);
    assign pos_a      = pos_w[AW-1:0];
    assign pos_le_cnt = (pos_w <= count_w);
    assign pos_lt_cnt = (pos_w < count_w);
    assign not_full   = (r_count != DEPTH_C);

    // Shared walk unit: one compare and one step of the index per cycle.
    assign walk_on  = r_up ? (r_idx > r_lim) : (r_idx < r_lim);
    assign idx_step = r_up ? (r_idx - ONE_C) : (r_idx + ONE_C);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_val       = r_val;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_up        = r_up;
        n_pend      = r_pend;
        n_tgt       = r_tgt;
        n_ok        = r_ok;
        n_rd        = r_rd;
        n_fpos      = r_fpos;
        n_fnd       = r_fnd;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tgt;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_pos   = i_position;
                    n_val   = i_item_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_ok    = 1'b0;
                n_rd    = '0;
                n_fpos  = '0;
                n_fnd   = 1'b0;
                n_pend  = 1'b0;
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_APPEND: begin
                        if (not_full) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_count[AW-1:0];
                            o_mem_wdata = r_val;
                            n_count     = r_count + ONE_C;
                            n_ok        = 1'b1;
                        end
                    end
                    CMD_INSERT: begin
                        if (not_full && pos_le_cnt) begin
                            n_idx   = r_count;
                            n_lim   = pos_w[CW-1:0];
                            n_up    = 1'b1;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_REMOVE: begin
                        if (pos_lt_cnt) begin
                            n_idx   = pos_w[CW-1:0];
                            n_lim   = r_count - ONE_C;
                            n_up    = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_READ: begin
                        if (pos_lt_cnt) begin
                            o_mem_raddr = pos_a;
                            n_state     = S_RDWAIT;
                        end
                    end
                    CMD_REPLACE: begin
                        if (pos_lt_cnt) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = pos_a;
                            o_mem_wdata = r_val;
                            n_ok        = 1'b1;
                        end
                    end
                    CMD_FIND: begin
                        n_idx   = '0;
                        n_state = S_FIND;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                // Retire the move read last cycle, then issue the next one.
                o_mem_we = r_pend;
                if (walk_on) begin
                    o_mem_raddr = idx_step[AW-1:0];
                    n_pend      = 1'b1;
                    n_tgt       = r_idx[AW-1:0];
                    n_idx       = idx_step;
                end else begin
                    n_pend = 1'b0;
                    if (r_up) begin
                        n_state = S_PUTVAL;
                    end else begin
                        n_count = r_count - ONE_C;
                        n_ok    = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_PUTVAL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = pos_a;
                o_mem_wdata = r_val;
                n_count     = r_count + ONE_C;
                n_ok        = 1'b1;
                n_state     = S_DONE;
            end
            S_FIND: begin
                if (r_pend && (i_mem_rdata == r_val)) begin
                    n_fnd   = 1'b1;
                    n_ok    = 1'b1;
                    n_fpos  = r_tgt;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (r_idx < r_count) begin
                    o_mem_raddr = r_idx[AW-1:0];
                    n_pend      = 1'b1;
                    n_tgt       = r_idx[AW-1:0];
                    n_idx       = r_idx + ONE_C;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_rd    = i_mem_rdata;
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_lim  <= n_lim;
        r_up   <= n_up;
        r_tgt  <= n_tgt;
        r_ok   <= n_ok;
        r_rd   <= n_rd;
        r_fpos <= n_fpos;
        r_fnd  <= n_fnd;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);

    assign o_result.ok             = r_ok;
    assign o_result.read_value     = r_rd;
    assign o_result.found_position = fpos_w[OAL_FPOS_W-1:0];
    assign o_result.found          = r_fnd;
    assign o_result.entry_count    = count_w[OAL_COUNT_W-1:0];
    assign o_result.is_empty       = (r_count == '0);

    `OAL_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)
    `OAL_ASSERT_IMPLY(a_write_in_list, i_clk, i_rst_n, o_mem_we,
        CMPW'(o_mem_waddr) <= count_w)
    `OAL_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n,
        (r_state == S_IDLE) && i_valid, r_state == S_EXEC)
    `OAL_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n,
        (r_state == S_IDLE) || (r_state == S_FIND) || (r_state == S_RDWAIT) ||
        (r_state == S_DONE), $stable(r_count))
    `OAL_ASSERT_IMPLY(a_found_ok, i_clk, i_rst_n, r_fnd && (r_state == S_DONE), r_ok)

endmodule

// ===== hdl/ordered_array_list_unit.sv =====
// Insert and remove walk the entries between the position and the end of the list; find walks
// from the head until a match or the count; append, replace, read and bad or unknown commands do not walk.
// One command at a time: the next word is taken once the result has moved to the output
// register, so the unit never takes a new word before the last one is done.
// Reset (synchronous, active low) empties the list and clears the handshake; stored
// entries are left as they are, since only positions below the count are ever read.
module ordered_array_list_unit import oal_pkg::*; #(
    parameter int DEPTH = OAL_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [OAL_CMD_W-1:0]   i_command,
    input  logic [OAL_POS_W-1:0]   i_position,
    input  logic [OAL_VALUE_W-1:0] i_item_value,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_ok,
    output logic [OAL_VALUE_W-1:0] o_read_value,
    output logic [OAL_FPOS_W-1:0]  o_found_position,
    output logic                   o_found,
    output logic [OAL_COUNT_W-1:0] o_entry_count,
    output logic                   o_is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                   seq_ready;
    logic                   seq_done;
    logic                   out_free;
    t_result                seq_result;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [OAL_VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [OAL_VALUE_W-1:0] mem_rdata;

    logic    r_out_valid;
    t_result r_out;

    // Hold the command channel whenever the sequencer is busy with a word.
    assign o_stall = !seq_ready;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_stall;

    oal_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_ready      (seq_ready),
        .o_done       (seq_done),
        .i_free       (out_free),
        .o_result     (seq_result),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    oal_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: load a finished result when free, drop the word once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done && out_free) begin
            r_out <= seq_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out.ok;
    assign o_read_value     = r_out.read_value;
    assign o_found_position = r_out.found_position;
    assign o_found          = r_out.found;
    assign o_entry_count    = r_out.entry_count;
    assign o_is_empty       = r_out.is_empty;

endmodule

// ===== verif/tb_ordered_array_list_unit.sv =====
// Self-checking testbench for ordered_array_list_unit: command words in, result words out.
// Depends on oal_pkg and the unit's RTL; predicts every result from its own copy of the list.
`default_nettype none

module tb_ordered_array_list_unit;
    import oal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the unit does not decode; it must answer them without touching the list.
    localparam logic [OAL_CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [OAL_CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    localparam int DRAIN_CYCLES = 100; // longer than the slowest walk over a full list
    localparam int HOLD_CYCLES  = 400; // long receiver hold-off in the pressure test
    localparam int LIST_AW      = $clog2(OAL_DEPTH);

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic                   o_stall;
    logic [OAL_CMD_W-1:0]   i_command    = CMD_APPEND;
    logic [OAL_POS_W-1:0]   i_position   = '0;
    logic [OAL_VALUE_W-1:0] i_item_value = '0;
    logic                   o_valid;
    logic                   i_stall      = 1'b0;
    logic                   o_ok;
    logic [OAL_VALUE_W-1:0] o_read_value;
    logic [OAL_FPOS_W-1:0]  o_found_position;
    logic                   o_found;
    logic [OAL_COUNT_W-1:0] o_entry_count;
    logic                   o_is_empty;

    // Shadow copy of the list, updated at the edge where each command word is taken.
    logic [OAL_VALUE_W-1:0] list_mem [OAL_DEPTH];
    int                     list_len = 0;

    // Results still owed by the unit, oldest first.
    t_result pending_results[$];

    int   error_count = 0;
    int   gap_pct     = 0;   // chance in a hundred that the sender idles a cycle
    int   stall_pct   = 0;   // chance in a hundred that the receiver stalls a cycle
    logic hold_stall  = 1'b0;

    ordered_array_list_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ok             (o_ok),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_found          (o_found),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty)
    );

    always #5ns i_clk = ~i_clk;

    // Apply one command to the shadow list and return the result word it must produce.
    // Bad positions, a full list and unused codes leave the list alone with ok low.
    function automatic t_result apply_command(logic [OAL_CMD_W-1:0] cmd,
                                              logic [OAL_POS_W-1:0] pos,
                                              logic [OAL_VALUE_W-1:0] val);
        t_result res;
        int      k;
        res = '0;
        case (cmd)
            CMD_APPEND: begin
                if (list_len < OAL_DEPTH) begin
                    list_mem[LIST_AW'(list_len)] = val;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (pos <= list_len && list_len < OAL_DEPTH) begin
                    for (k = list_len; k > pos; k--)
                        list_mem[LIST_AW'(k)] = list_mem[LIST_AW'(k - 1)];
                    list_mem[LIST_AW'(pos)] = val;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (pos < list_len) begin
                    for (k = pos; k + 1 < list_len; k++)
                        list_mem[LIST_AW'(k)] = list_mem[LIST_AW'(k + 1)];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (pos < list_len) begin
                    res.read_value = list_mem[LIST_AW'(pos)];
                    res.ok         = 1'b1;
                end
            end
            CMD_REPLACE: begin
                if (pos < list_len) begin
                    list_mem[LIST_AW'(pos)] = val;
                    res.ok                  = 1'b1;
                end
            end
            CMD_FIND: begin
                // First match wins; an absent value reports position zero.
                for (k = 0; k < list_len; k++) begin
                    if (list_mem[LIST_AW'(k)] == val) begin
                        res.found          = 1'b1;
                        res.found_position = k[OAL_FPOS_W-1:0];
                        break;
                    end
                end
                res.ok = res.found;
            end
            default: ;
        endcase
        res.entry_count = list_len[OAL_COUNT_W-1:0];
        res.is_empty    = (list_len == 0);
        return res;
    endfunction

    // Offer one command word, idling first at the sender's rate, and hold it until taken.
    // Valid stays high on return: the next call either replaces the word or lowers valid.
    task automatic send_word(input logic [OAL_CMD_W-1:0] cmd,
                             input logic [OAL_POS_W-1:0] pos,
                             input logic [OAL_VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(apply_command(cmd, pos, val));
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        gap_pct   = sender_pct;
        stall_pct = receiver_pct;
    endtask

    // One random command word. Most words have legal positions and many carry values
    // already in the list, so finds hit and shifts move real data. The rest is noise.
    task automatic random_word;
        logic [OAL_CMD_W-1:0]   cmd;
        logic [OAL_POS_W-1:0]   pos;
        logic [OAL_VALUE_W-1:0] val;
        int                     sel;
        int                     pick;
        sel = $urandom_range(0, 99);
        if (sel < 14)      cmd = CMD_APPEND;
        else if (sel < 32) cmd = CMD_INSERT;
        else if (sel < 66) cmd = CMD_REMOVE;
        else if (sel < 76) cmd = CMD_READ;
        else if (sel < 85) cmd = CMD_REPLACE;
        else if (sel < 97) cmd = CMD_FIND;
        else               cmd = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;

        if ($urandom_range(0, 99) < 12)
            pos = OAL_POS_W'($urandom_range(0, 127));
        else if (cmd == CMD_INSERT)
            pos = OAL_POS_W'($urandom_range(0, list_len));
        else if (list_len > 0)
            pos = OAL_POS_W'($urandom_range(0, list_len - 1));
        else
            pos = OAL_POS_W'($urandom_range(0, 127));

        pick = $urandom_range(0, 99);
        if (pick < 40 && list_len > 0)
            val = list_mem[LIST_AW'($urandom_range(0, list_len - 1))];
        else if (pick < 60)
            val = OAL_VALUE_W'($urandom_range(0, 7));
        else
            val = OAL_VALUE_W'($urandom_range(0, 16'hFFFF));
        send_word(cmd, pos, val);
    endtask

    // Hit every command, the position rejections and the field extremes on a short list.
    task automatic test_directed;
        set_idling(0, 0);
        send_word(CMD_FIND,      7'd0,   16'h0000);   // find on an empty list
        send_word(CMD_READ,      7'd0,   16'h0000);   // read with nothing stored
        send_word(CMD_REMOVE,    7'd0,   16'h0000);
        send_word(CMD_REPLACE,   7'd0,   16'hFFFF);
        send_word(CMD_INSERT,    7'd1,   16'h1111);   // insert past the end
        send_word(CMD_INSERT,    7'd0,   16'h1234);   // insert into an empty list
        send_word(CMD_APPEND,    7'd0,   16'hFFFF);
        send_word(CMD_APPEND,    7'd127, 16'h0000);   // append ignores position
        send_word(CMD_INSERT,    7'd3,   16'hA5A5);   // insert right at the end
        send_word(CMD_INSERT,    7'd1,   16'h5A5A);   // insert in the middle
        send_word(CMD_READ,      7'd0,   16'h0000);
        send_word(CMD_READ,      7'd4,   16'hFFFF);   // last entry
        send_word(CMD_READ,      7'd5,   16'h0000);   // one past the end
        send_word(CMD_READ,      7'd127, 16'h0000);
        send_word(CMD_REPLACE,   7'd3,   16'hFFFF);   // duplicate the value at two
        send_word(CMD_REPLACE,   7'd64,  16'h0F0F);   // replace out of range
        send_word(CMD_FIND,      7'd0,   16'hFFFF);   // first of two matches
        send_word(CMD_FIND,      7'd127, 16'hBEEF);   // absent value
        send_word(CMD_UNUSED_LO, 7'd0,   16'h0000);
        send_word(CMD_UNUSED_HI, 7'd127, 16'hFFFF);
        send_word(CMD_REMOVE,    7'd127, 16'h0000);
        send_word(CMD_REMOVE,    7'd1,   16'h0000);   // shift the tail down
        send_word(CMD_INSERT,    7'd64,  16'h0001);
        send_word(CMD_REMOVE,    7'd3,   16'h0000);   // last entry, no shift
        drain();
    endtask

    // Fill the list to the brim, poke at the full state, then empty it by random removes.
    task automatic test_full_list;
        logic [OAL_VALUE_W-1:0] last_val;
        while (list_len < OAL_DEPTH)
            send_word(CMD_APPEND, OAL_POS_W'($urandom_range(0, 127)),
                      OAL_VALUE_W'($urandom_range(0, 16'hFFFF)));
        send_word(CMD_APPEND, 7'd0, 16'h7777);        // full: rejected
        send_word(CMD_INSERT, 7'd0, 16'h7777);        // full: rejected
        send_word(CMD_INSERT, 7'd64, 16'h7777);
        send_word(CMD_READ,   7'd63, 16'h0000);
        last_val = list_mem[OAL_DEPTH-1];
        send_word(CMD_FIND,   7'd0, last_val);         // walk the whole list
        send_word(CMD_REMOVE, 7'd0, 16'h0000);         // longest shift
        send_word(CMD_INSERT, 7'd0, 16'hFFFF);         // longest shift up, full again
        send_word(CMD_REMOVE, 7'd64, 16'h0000);
        while (list_len > 0)
            send_word(CMD_REMOVE, OAL_POS_W'($urandom_range(0, list_len - 1)),
                      OAL_VALUE_W'($urandom_range(0, 16'hFFFF)));
        drain();
    endtask

    task automatic test_random(input int n_words);
        repeat (n_words)
            random_word();
        drain();
    endtask

    // Hold the result side for a long stretch while the sender keeps pushing, so the
    // unit parks a result and stalls its command input.
    task automatic test_backpressure;
        set_idling(0, 0);
        fork
            begin
                hold_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_stall <= 1'b0;
            end
            begin
                repeat (20)
                    random_word();
            end
        join
        drain();
    endtask

    // Receiver: stall at the current rate, or solidly while a hold-off is on.
    always @(posedge i_clk)
        i_stall <= hold_stall || ($urandom_range(0, 99) < stall_pct);

    // Compare every result word taken with the oldest owed result.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{ok: o_ok, read_value: o_read_value, found_position: o_found_position,
                    found: o_found, entry_count: o_entry_count, is_empty: o_is_empty};
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result word with none owed: ok=%0b rd=%h fpos=%0d",
                             $realtime, got.ok, got.read_value, got.found_position);
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok || got.read_value !== want.read_value ||
                    got.found_position !== want.found_position ||
                    got.found !== want.found || got.entry_count !== want.entry_count ||
                    got.is_empty !== want.is_empty) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $write("%0t: mismatch: expected ok=%0b rd=%h fpos=%0d found=%0b",
                               $realtime, want.ok, want.read_value, want.found_position,
                               want.found);
                        $write(" count=%0d empty=%0b, got ok=%0b rd=%h fpos=%0d",
                               want.entry_count, want.is_empty,
                               got.ok, got.read_value, got.found_position);
                        $display(" found=%0b count=%0d empty=%0b",
                                 got.found, got.entry_count, got.is_empty);
                    end
                end
            end
        end
    end

    initial begin
        // Hold reset, release it on an edge and start from the next one.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_list();
        test_backpressure();

        // Random traffic under each idling mix: none, sender sparse, receiver
        // stalling, then both lightly.
        set_idling(0, 0);
        test_random(175);
        set_idling(88, 0);
        test_random(175);
        set_idling(0, 88);
        test_random(175);
        set_idling(13, 13);
        test_random(175);

        // Let any stray result word surface before judging.
        set_idling(0, 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_ordered_array_list_unit: clean");
        else
            $display("tb_ordered_array_list_unit: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("tb_ordered_array_list_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/oal_pkg.sv
hdl/oal_store.sv
hdl/oal_seq.sv
hdl/ordered_array_list_unit.sv
verif/tb_ordered_array_list_unit.sv
